[rtl/srl_pkg.sv]
// srl_pkg: shared types and constants for the symbol range lookup block.
// Used by symbol_range_lookup and srl_checker; depends on nothing.
package srl_pkg;

   localparam int MAX_SYMBOLS_DEF  = 1024;
   localparam int ADDRESS_BITS_DEF = 32;

   // request op codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // register indexes on the csr port
   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   typedef struct packed {
      logic        op;
      logic [10:0] entry_index;
      logic [31:0] entry_start;
      logic [31:0] lookup_address;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [9:0]  symbol_index;
      logic [31:0] offset_in_symbol;
   } rsp_type;

endpackage

[rtl/srl_ram.sv]
// srl_ram: generic single write port, single read port RAM with registered read.
// Depends on nothing.
module srl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/symbol_range_lookup.sv]
// symbol_range_lookup: top level; table of symbol start offsets searched by bisection.
// Depends on srl_pkg and srl_ram (two copies of the start table).
//
// A load beat (op 0) writes one table slot in the cycle it is accepted, if its index
// is at most MAX_SYMBOLS, and gives no result; busy stays low. A lookup beat (op 1)
// keeps busy high for a read of the sentinel slot and then for P bisection probes
// (none when the offset is at or past the sentinel), P being at most
// floor(log2(symbol_count + 1)) + 1 (11 for 1024 symbols); each probe is one read
// of the slot under test and its successor from the two table copies, which have
// registered reads. The result is shown on rsp_valid / rsp_data for exactly one
// cycle, the first cycle with busy low again, and the next beat may be accepted in
// that same cycle. There is no way to hold the result off, so it must be captured
// then. The table has no reset: every slot a lookup can reach, sentinel included,
// must have been loaded first.
module symbol_range_lookup #(
   parameter int MAX_SYMBOLS  = srl_pkg::MAX_SYMBOLS_DEF,
   parameter int ADDRESS_BITS = srl_pkg::ADDRESS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  srl_pkg::req_type  req_data,
   output logic              rsp_valid,
   output srl_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import srl_pkg::*;

   localparam int DEPTH = MAX_SYMBOLS + 1;
   localparam int AB    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAX_SYMBOLS + 2);
   localparam int AW    = ADDRESS_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SENT  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] off_ff, off_in;
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [31:0]   base_ff;
   logic [10:0]   count_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic          csr_wr;
   logic          tbl_we;
   logic [AB-1:0] tbl_waddr;
   logic [AW-1:0] tbl_wdata;
   logic [IW-1:0] issue_idx;
   logic [IW-1:0] issue_nxt;
   logic [AW-1:0] slot_a;
   logic [AW-1:0] slot_b;
   logic [IW-1:0] cnt_clamp;
   logic [IW-1:0] nlo, nhi;
   logic          stop;
   logic          hit;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= '0;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_BASE:  base_ff  <= pwdata;
            REG_COUNT: count_ff <= pwdata[10:0];
            default:   ;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_COUNT) ? 32'(count_ff) : base_ff;

   // loads go to both copies so slot i and slot i+1 can be read together
   assign tbl_we    = accept && (req_data.op == OP_LOAD) &&
                      (32'(req_data.entry_index) <= 32'(MAX_SYMBOLS));
   assign tbl_waddr = AB'(32'(req_data.entry_index));
   assign tbl_wdata = AW'(64'(req_data.entry_start));
   assign issue_nxt = issue_idx + IW'(1);

   srl_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_tbl_a (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (issue_idx[AB-1:0]),
      .rd_data (slot_a)
   );

   srl_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_tbl_b (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (issue_nxt[AB-1:0]),
      .rd_data (slot_b)
   );

   assign cnt_clamp = (32'(count_ff) > 32'(MAX_SYMBOLS)) ? IW'(MAX_SYMBOLS)
                                                          : IW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      issue_idx    = mid_ff;
      nlo          = lo_ff;
      nhi          = hi_ff;
      stop         = 1'b0;
      hit          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.op == OP_LOOKUP)) begin
               off_in    = AW'(64'(req_data.lookup_address) - 64'(base_ff));
               cnt_in    = cnt_clamp;
               issue_idx = cnt_clamp;
               state_in  = ST_SENT;
            end
         end
         ST_SENT: begin
            // slot_a holds the sentinel
            if (off_ff >= slot_a) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               lo_in     = '0;
               hi_in     = cnt_ff;
               mid_in    = cnt_ff >> 1;
               issue_idx = cnt_ff >> 1;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            hit = (off_ff >= slot_a) && (mid_ff < cnt_ff) && (off_ff < slot_b);
            if (hit) begin
               rsp_valid_in            = 1'b1;
               rsp_in.found            = 1'b1;
               rsp_in.symbol_index     = 10'(mid_ff);
               rsp_in.offset_in_symbol = 32'(64'(off_ff - slot_a));
               state_in                = ST_IDLE;
            end else begin
               if (off_ff < slot_a) begin
                  // below slot zero the search gives up
                  if (mid_ff == '0) begin
                     stop = 1'b1;
                  end else begin
                     nhi = mid_ff - IW'(1);
                  end
               end else begin
                  nlo = mid_ff + IW'(1);
               end
               if (!stop && (nlo <= nhi)) begin
                  lo_in     = nlo;
                  hi_in     = nhi;
                  mid_in    = nlo + ((nhi - nlo) >> 1);
                  issue_idx = nlo + ((nhi - nlo) >> 1);
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[rtl/srl_checker.sv]
// srl_checker: port-level assertions for symbol_range_lookup, bound to the top level.
// Depends on srl_pkg.
module srl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input srl_pkg::req_type  req_data,
   input logic              rsp_valid,
   input srl_pkg::rsp_type  rsp_data
);
   import srl_pkg::*;

   // a lookup beat always occupies the block
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_LOOKUP) |=> busy)
      else $error("lookup beat did not raise busy");

   // a load beat finishes in its own cycle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_LOAD) |=> !busy && !rsp_valid)
      else $error("load beat left the block busy or gave a result");

   // the result closes the lookup that was running
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result not at the end of a lookup");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in a row");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         (rsp_data.symbol_index == '0) && (rsp_data.offset_in_symbol == '0))
      else $error("miss with nonzero index or offset");
endmodule

bind symbol_range_lookup srl_checker u_srl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
